>>> rtl/mer_pkg.sv
package mer_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int AXIS_BITS_DEF  = 10;
  // decision value wraps at this width whatever the axis and coordinate widths
  localparam int DEC_BITS       = 36;

  typedef enum logic [1:0] {
    MUL_LOAD,   // a*a, b*b from the incoming word
    MUL_STEP,   // b^2*x, a^2*y
    MUL_INIT1,  // a^2*b for the region 1 start value
    MUL_INIT2   // b^2*a for the region 2 start value
  } mul_sel_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_SQ,
    UPD_R1,
    UPD_STEP,
    UPD_R2
  } upd_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     cap_en;
    upd_e     upd;
    logic     in_r2;
    logic     emit_en;
    logic     emit_plot;
    logic     emit_done;
  } mer_cmd_t;

  typedef struct packed {
    logic out_free;
    logic go;
  } mer_sts_t;

endpackage

>>> rtl/mer_ctrl.sv
module mer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  input  mer_pkg::mer_sts_t sts_i,
  output mer_pkg::mer_cmd_t cmd_o
);

  localparam logic [2:0] ST_WAIT     = 3'd0;
  localparam logic [2:0] ST_SQ_WR    = 3'd1;
  localparam logic [2:0] ST_IB_MUL   = 3'd2;
  localparam logic [2:0] ST_R1_INIT  = 3'd3;
  localparam logic [2:0] ST_STEP     = 3'd4;
  localparam logic [2:0] ST_R2_INIT  = 3'd5;
  localparam logic [2:0] ST_IDLE_ADV = 3'd6;

  localparam logic [1:0] RG_IDLE = 2'd0;
  localparam logic [1:0] RG_ONE  = 2'd1;
  localparam logic [1:0] RG_TWO  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] region_q, region_d;

  assign in_ready_o = (state_q == ST_WAIT);

  always_comb begin
    state_d       = state_q;
    region_d      = region_q;
    cmd_o         = '0;
    cmd_o.mul_sel = mer_pkg::MUL_STEP;
    cmd_o.upd     = mer_pkg::UPD_NONE;
    cmd_o.in_r2   = (region_q == RG_TWO);
    case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.mul_en = 1'b1;
          if (!in_mode_i) begin
            cmd_o.mul_sel = mer_pkg::MUL_LOAD;
            cmd_o.cap_en  = 1'b1;
            state_d       = ST_SQ_WR;
          end else if (region_q == RG_ONE || region_q == RG_TWO) begin
            state_d = ST_STEP;
          end else begin
            state_d = ST_IDLE_ADV;
          end
        end
      end
      ST_SQ_WR: begin
        cmd_o.upd = mer_pkg::UPD_SQ;
        state_d   = ST_IB_MUL;
      end
      ST_IB_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mer_pkg::MUL_INIT1;
        state_d       = ST_R1_INIT;
      end
      ST_R1_INIT: begin
        if (sts_i.out_free) begin
          cmd_o.upd     = mer_pkg::UPD_R1;
          cmd_o.emit_en = 1'b1;
          region_d      = RG_ONE;
          state_d       = ST_WAIT;
        end
      end
      ST_STEP: begin
        if (sts_i.out_free) begin
          if (sts_i.go) begin
            cmd_o.upd       = mer_pkg::UPD_STEP;
            cmd_o.emit_en   = 1'b1;
            cmd_o.emit_plot = 1'b1;
            state_d         = ST_WAIT;
          end else if (region_q == RG_ONE) begin
            // region 1 exhausted: restart at (a,0)
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = mer_pkg::MUL_INIT2;
            state_d       = ST_R2_INIT;
          end else begin
            cmd_o.emit_en   = 1'b1;
            cmd_o.emit_done = 1'b1;
            region_d        = RG_IDLE;
            state_d         = ST_WAIT;
          end
        end
      end
      ST_R2_INIT: begin
        if (sts_i.out_free) begin
          cmd_o.upd     = mer_pkg::UPD_R2;
          cmd_o.emit_en = 1'b1;
          region_d      = RG_TWO;
          state_d       = ST_WAIT;
        end
      end
      ST_IDLE_ADV: begin
        if (sts_i.out_free) begin
          cmd_o.emit_en   = 1'b1;
          cmd_o.emit_done = 1'b1;
          region_d        = RG_IDLE;
          state_d         = ST_WAIT;
        end
      end
      default: begin
        state_d  = ST_WAIT;
        region_d = RG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT;
      region_q <= RG_IDLE;
    end else begin
      state_q  <= state_d;
      region_q <= region_d;
    end
  end

endmodule

>>> rtl/mer_dpath.sv
module mer_dpath #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  localparam int IN_TW     = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
  localparam int OUT_TW    = ((8 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IN_TW-1:0]  in_data_i,
  input  mer_pkg::mer_cmd_t cmd_i,
  output mer_pkg::mer_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_TW-1:0] out_data_o,
  output logic [1:0]        out_user_o
);

  localparam int CW = COORD_BITS;
  localparam int AW = AXIS_BITS;
  localparam int SW = 2 * AW;
  localparam int BW = ((AW > CW) ? AW : CW) + 1;
  localparam int PW = SW + 1 + BW;
  localparam int DW = mer_pkg::DEC_BITS;
  localparam int OW = CW + 2;

  logic [CW-1:0] in_cx, in_cy;
  logic [AW-1:0] in_a, in_b;

  assign in_cx = in_data_i[CW-1:0];
  assign in_cy = in_data_i[2*CW-1:CW];
  assign in_a  = in_data_i[2*CW+AW-1:2*CW];
  assign in_b  = in_data_i[2*CW+2*AW-1:2*CW+AW];

  logic [CW-1:0] hcx_q, hcy_q;
  logic [AW-1:0] ha_q, hb_q;
  logic [SW-1:0] aa_q, aa_d, bb_q, bb_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [DW-1:0] d_q, d_d;

  // two multipliers, products registered before use
  logic [SW-1:0]        opa0, opa1;
  logic signed [BW-1:0] opb0, opb1;
  logic signed [PW-1:0] p0_q, p0_d, p1_q, p1_d;

  always_comb begin
    opa0 = '0;
    opb0 = '0;
    opa1 = '0;
    opb1 = '0;
    case (cmd_i.mul_sel)
      mer_pkg::MUL_LOAD: begin
        opa0 = SW'(in_a);
        opb0 = $signed(BW'(in_a));
        opa1 = SW'(in_b);
        opb1 = $signed(BW'(in_b));
      end
      mer_pkg::MUL_STEP: begin
        opa0 = bb_q;
        opb0 = BW'($signed(x_q));
        opa1 = aa_q;
        opb1 = BW'($signed(y_q));
      end
      mer_pkg::MUL_INIT1: begin
        opa0 = aa_q;
        opb0 = $signed(BW'(hb_q));
      end
      mer_pkg::MUL_INIT2: begin
        opa0 = bb_q;
        opb0 = $signed(BW'(ha_q));
      end
      default: begin
        opa0 = '0;
      end
    endcase
  end

  assign p0_d = $signed({1'b0, opa0}) * opb0;
  assign p1_d = $signed({1'b0, opa1}) * opb1;

  // loop tests: exact compares on the full products
  logic zero_ax, go;
  assign zero_ax = (aa_q == '0) && (bb_q == '0) && (x_q != '0);
  assign go      = cmd_i.in_r2 ? (p0_q > p1_q) : ((p0_q <= p1_q) && !zero_ax);

  // decision arithmetic modulo 2^DW
  logic [DW-1:0] aa_w, bb_w, px_w, py_w;
  logic [DW-1:0] r1_base, r1_ext, r2_base, r2_ext, init1, init2, step_d;
  logic          d_pos, d_gt;

  assign aa_w = DW'(aa_q);
  assign bb_w = DW'(bb_q);
  assign px_w = DW'(p0_q);
  assign py_w = DW'(p1_q);

  assign r1_base = (px_w << 2) + (bb_w << 2) + (bb_w << 1);
  assign r1_ext  = (aa_w << 2) - (py_w << 2);
  assign r2_base = (py_w << 2) + (aa_w << 2) + (aa_w << 1);
  assign r2_ext  = (bb_w << 2) - (px_w << 2);
  assign init1   = (bb_w << 1) + aa_w - (px_w << 1);
  assign init2   = (aa_w << 1) + bb_w - (px_w << 1);

  assign d_pos  = !d_q[DW-1];
  assign d_gt   = d_pos && (d_q != '0);
  assign step_d = cmd_i.in_r2 ? (d_q + r2_base + (d_gt ? r2_ext : '0))
                              : (d_q + r1_base + (d_pos ? r1_ext : '0));

  always_comb begin
    aa_d = aa_q;
    bb_d = bb_q;
    x_d  = x_q;
    y_d  = y_q;
    d_d  = d_q;
    case (cmd_i.upd)
      mer_pkg::UPD_SQ: begin
        aa_d = p0_q[SW-1:0];
        bb_d = p1_q[SW-1:0];
      end
      mer_pkg::UPD_R1: begin
        x_d = '0;
        y_d = CW'(hb_q);
        d_d = init1;
      end
      mer_pkg::UPD_STEP: begin
        d_d = step_d;
        if (cmd_i.in_r2) begin
          y_d = y_q + CW'(1);
          if (d_gt) x_d = x_q - CW'(1);
        end else begin
          x_d = x_q + CW'(1);
          if (d_pos) y_d = y_q - CW'(1);
        end
      end
      mer_pkg::UPD_R2: begin
        x_d = CW'(ha_q);
        y_d = '0;
        d_d = init2;
      end
      default: begin
        d_d = d_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      hcx_q <= in_cx;
      hcy_q <= in_cy;
      ha_q  <= in_a;
      hb_q  <= in_b;
    end
    if (cmd_i.mul_en) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
    aa_q <= aa_d;
    bb_q <= bb_d;
    x_q  <= x_d;
    y_q  <= y_d;
    d_q  <= d_d;
  end

  // four symmetric points
  logic signed [OW-1:0] cx_e, cy_e, x_e, y_e;
  logic [OUT_TW-1:0]    word_d, word_q;
  logic [1:0]           user_q;
  logic                 full_q, full_d;

  assign cx_e = $signed(OW'(hcx_q));
  assign cy_e = $signed(OW'(hcy_q));
  assign x_e  = OW'($signed(x_q));
  assign y_e  = OW'($signed(y_q));

  always_comb begin
    word_d = '0;
    if (cmd_i.emit_plot) begin
      word_d[OW-1:0]      = cx_e + x_e;
      word_d[2*OW-1:OW]   = cy_e + y_e;
      word_d[3*OW-1:2*OW] = cx_e - x_e;
      word_d[4*OW-1:3*OW] = cy_e + y_e;
      word_d[5*OW-1:4*OW] = cx_e + x_e;
      word_d[6*OW-1:5*OW] = cy_e - y_e;
      word_d[7*OW-1:6*OW] = cx_e - x_e;
      word_d[8*OW-1:7*OW] = cy_e - y_e;
    end
  end

  assign sts_o.out_free = !full_q || out_ready_i;
  assign sts_o.go       = go;

  always_comb begin
    full_d = full_q;
    if (cmd_i.emit_en) full_d = 1'b1;
    else if (out_ready_i) full_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      word_q <= word_d;
      user_q <= {cmd_i.emit_done, cmd_i.emit_plot};
    end
  end

  assign out_valid_o = full_q;
  assign out_data_o  = word_q;
  assign out_user_o  = user_q;

endmodule

>>> rtl/midpoint_ellipse_raster_core.sv
// channel  dir  tdata (low bit up)                            tuser
// s_axis   in   center_x, center_y, semi_a, semi_b, zero pad  mode (0 start, 1 advance)
// m_axis   out  pp_x, pp_y, mp_x, mp_y, pm_x, pm_y, mm_x, mm_y  pixel_valid, ellipse_done
//
// An advance word is accepted with both products b^2*x and a^2*y, then compared and the
// decision updated. A start word goes through squares, write, a^2*b and load, and a region
// switch through products, step test with b^2*a and load.
// One word is in work at a time; the output register holds one result, so a stalled
// m_axis only holds the core once a second result is ready. Reset is asynchronous.
module midpoint_ellipse_raster_core #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  localparam int IN_TW     = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
  localparam int OUT_TW    = ((8 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,  // center_x, center_y, semi_a, semi_b
  input  logic              s_axis_tuser,  // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,  // pp_x, pp_y, mp_x, mp_y, pm_x, pm_y, mm_x, mm_y
  output logic [1:0]        m_axis_tuser   // pixel_valid, ellipse_done
);

  mer_pkg::mer_cmd_t cmd;
  mer_pkg::mer_sts_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mer_dpath #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

>>> rtl/mer_chk.sv
module mer_chk #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  localparam int OUT_TW    = ((8 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TW-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);

  localparam int OW = COORD_BITS + 2;

  logic [OW-1:0] pp_x, pp_y, mp_y, pm_x;

  assign pp_x = m_axis_tdata[OW-1:0];
  assign pp_y = m_axis_tdata[2*OW-1:OW];
  assign mp_y = m_axis_tdata[4*OW-1:3*OW];
  assign pm_x = m_axis_tdata[5*OW-1:4*OW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("pixel and done flagged together");

  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("coordinates not cleared on a word without pixels");

  a_symmetry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (pp_y == mp_y) && (pp_x == pm_x))
    else $error("symmetric points disagree");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in work");

endmodule

bind midpoint_ellipse_raster_core mer_chk #(
  .COORD_BITS (COORD_BITS)
) u_mer_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_midpoint_ellipse_raster_core.sv
module tb_midpoint_ellipse_raster_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = mer_pkg::COORD_BITS_DEF;
  localparam int AW     = mer_pkg::AXIS_BITS_DEF;
  localparam int OW     = CW + 2;
  localparam int IN_TW  = ((2 * CW + 2 * AW + 7) / 8) * 8;
  localparam int OUT_TW = ((8 * OW + 7) / 8) * 8;
  localparam int N_WORDS = 1500;
  localparam int QUIET_WORDS = 150;

  typedef enum logic { MODE_START = 1'b0, MODE_ADVANCE = 1'b1 } mode_e;
  typedef enum int { SHAPE_IDLE = 0, SHAPE_UPPER = 1, SHAPE_LOWER = 2 } region_e;

  typedef struct {
    logic [7:0][OW-1:0] pts;  // pp_x, pp_y, mp_x, mp_y, pm_x, pm_y, mm_x, mm_y
    logic               plot;
    logic               done;
  } pixel_word_t;

  class ellipse_tracker;
    region_e     region;
    longint      pos_x, pos_y, dec, a_sq, b_sq, ctr_x, ctr_y, semi_a;
    pixel_word_t expected_pixels[$];
    int          errors;
    string       coord_name[8];

    function new();
      region = SHAPE_IDLE;
      pos_x = 0; pos_y = 0; dec = 0; a_sq = 0; b_sq = 0;
      ctr_x = 0; ctr_y = 0; semi_a = 0;
      errors = 0;
      coord_name = '{"pp_x", "pp_y", "mp_x", "mp_y", "pm_x", "pm_y", "mm_x", "mm_y"};
    endfunction

    static function longint wrap_to(longint v, int bits);
      longint m;
      longint u;
      m = (longint'(1) << bits) - 1;
      u = v & m;
      if (((u >> (bits - 1)) & 1) != 0) return u - m - 1;
      return u;
    endfunction

    function void push_pixels(bit plot, bit done);
      pixel_word_t w;
      w.pts  = '0;
      w.plot = plot;
      w.done = done;
      if (plot) begin
        w.pts[0] = OW'(ctr_x + pos_x);
        w.pts[1] = OW'(ctr_y + pos_y);
        w.pts[2] = OW'(ctr_x - pos_x);
        w.pts[3] = OW'(ctr_y + pos_y);
        w.pts[4] = OW'(ctr_x + pos_x);
        w.pts[5] = OW'(ctr_y - pos_y);
        w.pts[6] = OW'(ctr_x - pos_x);
        w.pts[7] = OW'(ctr_y - pos_y);
      end
      expected_pixels.push_back(w);
    endfunction

    function void note_word(mode_e mode, logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [AW-1:0] a, logic [AW-1:0] b);
      longint aa, bb, nd, la, lb;
      bit     go;
      aa = a_sq;
      bb = b_sq;
      if (mode == MODE_START) begin
        la = longint'(a);
        lb = longint'(b);
        ctr_x  = longint'(cx);
        ctr_y  = longint'(cy);
        semi_a = la;
        a_sq   = la * la;
        b_sq   = lb * lb;
        pos_x  = 0;
        pos_y  = wrap_to(lb, CW);
        dec    = wrap_to(2 * b_sq + a_sq * (1 - 2 * lb), mer_pkg::DEC_BITS);
        region = SHAPE_UPPER;
        push_pixels(1'b0, 1'b0);
      end else if (region == SHAPE_UPPER) begin
        go = (bb * pos_x) <= (aa * pos_y);
        // degenerate point ellipse: plot the centre once, then leave the region
        if (aa == 0 && bb == 0 && pos_x != 0) go = 1'b0;
        if (go) begin
          push_pixels(1'b1, 1'b0);
          if (dec >= 0) begin
            nd = dec + 4 * aa * (1 - pos_y) + bb * (4 * pos_x + 6);
            pos_y = wrap_to(pos_y - 1, CW);
          end else begin
            nd = dec + bb * (4 * pos_x + 6);
          end
          dec   = wrap_to(nd, mer_pkg::DEC_BITS);
          pos_x = wrap_to(pos_x + 1, CW);
        end else begin
          pos_x  = wrap_to(semi_a, CW);
          pos_y  = 0;
          dec    = wrap_to(2 * aa + bb * (1 - 2 * semi_a), mer_pkg::DEC_BITS);
          region = SHAPE_LOWER;
          push_pixels(1'b0, 1'b0);
        end
      end else if (region == SHAPE_LOWER) begin
        if ((bb * pos_x) > (aa * pos_y)) begin
          push_pixels(1'b1, 1'b0);
          if (dec > 0) begin
            nd = dec + 4 * bb * (1 - pos_x) + aa * (4 * pos_y + 6);
            pos_x = wrap_to(pos_x - 1, CW);
          end else begin
            nd = dec + aa * (4 * pos_y + 6);
          end
          dec   = wrap_to(nd, mer_pkg::DEC_BITS);
          pos_y = wrap_to(pos_y + 1, CW);
        end else begin
          region = SHAPE_IDLE;
          push_pixels(1'b0, 1'b1);
        end
      end else begin
        region = SHAPE_IDLE;
        push_pixels(1'b0, 1'b1);
      end
    endfunction

    function void check_word(logic [OUT_TW-1:0] data, logic [1:0] user);
      pixel_word_t        w;
      logic [7:0][OW-1:0] got;
      got = data[8*OW-1:0];
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got tdata=%h tuser=%b",
                 $time, data, user);
        errors++;
        return;
      end
      w = expected_pixels.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got[i] !== w.pts[i]) begin
          $display("%0t: %s expected %0d got %0d", $time, coord_name[i],
                   $signed(w.pts[i]), $signed(got[i]));
          errors++;
        end
      end
      if (user[0] !== w.plot) begin
        $display("%0t: pixel_valid expected %b got %b", $time, w.plot, user[0]);
        errors++;
      end
      if (user[1] !== w.done) begin
        $display("%0t: ellipse_done expected %b got %b", $time, w.done, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata;   // center_x, center_y, semi_a, semi_b
  logic              s_axis_tuser;   // mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_TW-1:0] m_axis_tdata;   // pp_x, pp_y, mp_x, mp_y, pm_x, pm_y, mm_x, mm_y
  logic [1:0]        m_axis_tuser;   // pixel_valid, ellipse_done

  ellipse_tracker tracker = new();
  int             words_sent = 0;
  bit             quiet = 1'b0;

  midpoint_ellipse_raster_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic push_word(mode_e mode, logic [CW-1:0] cx, logic [CW-1:0] cy,
                           logic [AW-1:0] a, logic [AW-1:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= IN_TW'({b, a, cy, cx});
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_word(mode, cx, cy, a, b);
    words_sent++;
  endtask

  // advance words carry random junk in the unused fields
  task automatic push_advance();
    push_word(MODE_ADVANCE, CW'($urandom), CW'($urandom), AW'($urandom), AW'($urandom));
  endtask

  // start a shape and step it until it ends or the cap cuts it short
  task automatic draw_ellipse(logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [AW-1:0] a, logic [AW-1:0] b, int cap);
    int steps;
    steps = 0;
    push_word(MODE_START, cx, cy, a, b);
    while (tracker.region != SHAPE_IDLE && steps < cap) begin
      push_advance();
      steps++;
    end
  endtask

  initial begin
    int            pick;
    int            cap;
    logic [AW-1:0] a, b;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= MODE_START;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle advance straight after reset
    push_advance();
    // point ellipse: centre once, switch, end
    draw_ellipse('0, '0, '0, '0, 10);
    push_advance();
    draw_ellipse('1, '1, '1, '1, 2);
    // flat ellipse, y steps to -1
    draw_ellipse('0, '0, AW'(5), AW'(0), 10);
    draw_ellipse(CW'(100), '1, AW'(0), AW'(7), 10);
    draw_ellipse(CW'(1024), '0, AW'(3), AW'(2), 20);

    while (words_sent < N_WORDS) begin
      quiet = words_sent > N_WORDS - QUIET_WORDS;
      pick = $urandom_range(0, 19);
      cap  = 100000;
      if (pick < 13) begin
        a = AW'($urandom_range(0, 24));
        b = AW'($urandom_range(0, 24));
      end else if (pick < 16) begin
        a = AW'($urandom_range(0, 120));
        b = AW'($urandom_range(0, 120));
      end else begin
        // large axes, cut short by a restart mid-shape
        a = AW'($urandom);
        b = AW'($urandom);
        cap = $urandom_range(1, 40);
      end
      draw_ellipse(CW'($urandom), CW'($urandom), a, b, cap);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) push_advance();
      end
    end
    quiet = 1'b1;

    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check every accepted word, stall in short random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        tracker.check_word(m_axis_tdata, m_axis_tuser);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
